// File: hw/rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg: flight phase sequencer shared definitions
// Widths, register indexes, phase codes and the payload types that travel
// between the stages of the sequencer.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int DataWidth    = 24;
  localparam int CountWidth   = 8;
  localparam int TimeWidth    = 32;
  localparam int PhaseWidth   = 3;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 32;

  // register indexes
  localparam logic [CfgIdxWidth-1:0] CfgLaunchAccel = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgConfirm     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgCoastDelay  = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgTiltLock    = 2'd3;

  // register reset values
  localparam logic signed [DataWidth-1:0] RstLaunchAccel = DataWidth'(7680);
  localparam logic [CountWidth-1:0]       RstConfirm     = CountWidth'(5);
  localparam logic [TimeWidth-1:0]        RstCoastDelay  = TimeWidth'(3000000);
  localparam logic signed [DataWidth-1:0] RstTiltLock    = DataWidth'(7680);

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  // external phase codes
  localparam logic [PhaseWidth-1:0] PhaseCodeIdle     = 3'd0;
  localparam logic [PhaseWidth-1:0] PhaseCodeLaunched = 3'd1;
  localparam logic [PhaseWidth-1:0] PhaseCodeCoasting = 3'd2;
  localparam logic [PhaseWidth-1:0] PhaseCodeApogee   = 3'd3;
  localparam logic [PhaseWidth-1:0] PhaseCodeDescent  = 3'd4;
  localparam logic [PhaseWidth-1:0] PhaseCodeFault    = 3'd5;

  localparam logic OpSample = 1'b0;
  localparam logic OpFault  = 1'b1;

  typedef enum logic [5:0] {
    PhIdle     = 6'b000001,
    PhLaunched = 6'b000010,
    PhCoasting = 6'b000100,
    PhApogee   = 6'b001000,
    PhDescent  = 6'b010000,
    PhFault    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic signed [DataWidth-1:0] launch_accel_threshold;
    logic [CountWidth-1:0]       confirm_samples;
    logic [TimeWidth-1:0]        coast_delay_us;
    logic signed [DataWidth-1:0] tilt_lock;
  } cfg_t;

  typedef struct packed {
    logic                        operation;
    logic signed [DataWidth-1:0] vertical_accel;
    logic signed [DataWidth-1:0] vertical_velocity;
    logic signed [DataWidth-1:0] tilt_angle;
    logic [TimeWidth-1:0]        time_us;
  } sample_t;

  typedef struct packed {
    logic [PhaseWidth-1:0] phase;
    logic                  brakes_allowed;
  } result_t;

  function automatic logic [PhaseWidth-1:0] phase_code(phase_e ph);
    logic [PhaseWidth-1:0] code;
    case (ph)
      PhIdle:     code = PhaseCodeIdle;
      PhLaunched: code = PhaseCodeLaunched;
      PhCoasting: code = PhaseCodeCoasting;
      PhApogee:   code = PhaseCodeApogee;
      PhDescent:  code = PhaseCodeDescent;
      PhFault:    code = PhaseCodeFault;
      default:    code = PhaseCodeFault;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/fps_sample_if.sv
// ----------------------------------------------------------------------------
// fps_sample_if: sample request channel
// Valid/ready channel carrying one estimator sample or a fault trigger.
// ----------------------------------------------------------------------------
interface fps_sample_if import fps_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic signed [DataWidth-1:0] vertical_accel;
  logic signed [DataWidth-1:0] vertical_velocity;
  logic signed [DataWidth-1:0] tilt_angle;
  logic [TimeWidth-1:0]        time_us;

  modport source (
    output valid, operation, vertical_accel, vertical_velocity, tilt_angle, time_us,
    input  ready
  );
  modport sink (
    input  valid, operation, vertical_accel, vertical_velocity, tilt_angle, time_us,
    output ready
  );
endinterface

// File: hw/rtl/fps_result_if.sv
// ----------------------------------------------------------------------------
// fps_result_if: phase result channel
// Valid/ready channel carrying the flight phase and the brake permit.
// ----------------------------------------------------------------------------
interface fps_result_if import fps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PhaseWidth-1:0] phase;
  logic                  brakes_allowed;

  modport source (
    output valid, phase, brakes_allowed,
    input  ready
  );
  modport sink (
    input  valid, phase, brakes_allowed,
    output ready
  );
endinterface

// File: hw/rtl/flight_phase_sequencer.sv
// ----------------------------------------------------------------------------
// flight_phase_sequencer: rocket flight phase tracker
// Follows idle, launched, coasting, apogee, descent and fault from a stream
// of estimator samples and reports the phase with a brake-deploy permit.
// ----------------------------------------------------------------------------
// One request is taken every cycle, as long as the result channel keeps up:
// the request is registered, the phase logic acts on it combinationally, and
// the result lands in the output register. The only thing that slows the
// stream is the consumer holding off the result channel; while the result
// register is full and not taken, requests wait. Configuration writes take
// effect on the next cycle and should be made with no request in flight.
module flight_phase_sequencer import fps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  fps_sample_if.sink              sample_i,
  fps_result_if.source            result_o
);

  cfg_t    cfg;
  sample_t in_data, s1_data;
  logic    s1_valid, out_free, s1_fire;
  result_t core_result, out_data;

  assign in_data.operation         = sample_i.operation;
  assign in_data.vertical_accel    = sample_i.vertical_accel;
  assign in_data.vertical_velocity = sample_i.vertical_velocity;
  assign in_data.tilt_angle        = sample_i.tilt_angle;
  assign in_data.time_us           = sample_i.time_us;

  assign s1_fire = s1_valid && out_free;

  fps_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  fps_in_stage u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i (sample_i.valid),
    .in_data_i  (in_data),
    .in_ready_o (sample_i.ready),
    .take_i     (out_free),
    .valid_o    (s1_valid),
    .data_o     (s1_data)
  );

  fps_phase_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .fire_i   (s1_fire),
    .sample_i (s1_data),
    .result_o (core_result)
  );

  fps_out_stage u_out (
    .clk_i,
    .rst_ni,
    .load_i      (s1_fire),
    .data_i      (core_result),
    .free_o      (out_free),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_data_o  (out_data)
  );

  assign result_o.phase          = out_data.phase;
  assign result_o.brakes_allowed = out_data.brakes_allowed;

endmodule

// File: hw/rtl/fps_cfg_regs.sv
// ----------------------------------------------------------------------------
// fps_cfg_regs: configuration registers
// Holds launch threshold, confirm count, coast delay and tilt lock.
// ----------------------------------------------------------------------------
module fps_cfg_regs import fps_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLaunchAccel: cfg_d.launch_accel_threshold = cfg_wdata_i[DataWidth-1:0];
        CfgConfirm:     cfg_d.confirm_samples        = cfg_wdata_i[CountWidth-1:0];
        CfgCoastDelay:  cfg_d.coast_delay_us         = cfg_wdata_i[TimeWidth-1:0];
        CfgTiltLock:    cfg_d.tilt_lock              = cfg_wdata_i[DataWidth-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.launch_accel_threshold <= RstLaunchAccel;
      cfg_q.confirm_samples        <= RstConfirm;
      cfg_q.coast_delay_us         <= RstCoastDelay;
      cfg_q.tilt_lock              <= RstTiltLock;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/fps_in_stage.sv
// ----------------------------------------------------------------------------
// fps_in_stage: input register
// Captures one sample request per cycle and holds it until the phase logic
// can pass its result on.
// ----------------------------------------------------------------------------
module fps_in_stage import fps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  sample_t in_data_i,
  output logic    in_ready_o,
  input  logic    take_i,
  output logic    valid_o,
  output sample_t data_o
);

  logic    valid_q, valid_d;
  sample_t data_q;

  // free slot, or the held sample leaves this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/fps_phase_core.sv
// ----------------------------------------------------------------------------
// fps_phase_core: flight phase state and transition logic
// Applies one sample or fault to the phase state and forms the result.
// ----------------------------------------------------------------------------
module fps_phase_core import fps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fire_i,
  input  sample_t sample_i,
  output result_t result_o
);

  phase_e                      phase_q, phase_d;
  logic [CountWidth-1:0]       count_q, count_d;
  logic [TimeWidth-1:0]        launch_time_q, launch_time_d;
  logic signed [DataWidth-1:0] tilt_q, tilt_d;

  logic signed [DataWidth-1:0] accel, vel;
  logic [CountWidth-1:0]       count_inc;
  logic [TimeWidth-1:0]        elapsed;

  assign accel     = sample_i.vertical_accel;
  assign vel       = sample_i.vertical_velocity;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + CountWidth'(1);
  // wraps modulo 2^32 like the timestamp
  assign elapsed   = sample_i.time_us - launch_time_q;

  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    launch_time_d = launch_time_q;
    tilt_d        = tilt_q;
    if (sample_i.operation == OpFault) begin
      phase_d = PhFault;
    end else begin
      tilt_d = sample_i.tilt_angle;
      case (phase_q)
        PhIdle: begin
          if (accel >= cfg_i.launch_accel_threshold) begin
            if (count_inc >= cfg_i.confirm_samples) begin
              phase_d       = PhLaunched;
              launch_time_d = sample_i.time_us;
              count_d       = '0;
            end else begin
              count_d = count_inc;
            end
          end else begin
            count_d = '0;
          end
        end
        PhLaunched: begin
          if (elapsed >= cfg_i.coast_delay_us) phase_d = PhCoasting;
        end
        PhCoasting: begin
          if (vel <= 0) phase_d = PhApogee;
        end
        PhApogee: phase_d = PhDescent;
        default:  phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhIdle;
      count_q       <= '0;
      launch_time_q <= '0;
      tilt_q        <= '0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      count_q       <= count_d;
      launch_time_q <= launch_time_d;
      tilt_q        <= tilt_d;
    end
  end

  assign result_o.phase          = phase_code(phase_d);
  assign result_o.brakes_allowed = (phase_d == PhCoasting) && (tilt_d <= cfg_i.tilt_lock);

endmodule

// File: hw/rtl/fps_out_stage.sv
// ----------------------------------------------------------------------------
// fps_out_stage: result register
// Holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
module fps_out_stage import fps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hw/rtl/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker: port-level checks for the flight phase sequencer
// Watches the result channel for phase ordering and permit consistency.
// ----------------------------------------------------------------------------
module fps_checker import fps_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic [PhaseWidth-1:0] res_phase_i,
  input logic                  res_brakes_i
);

  logic res_take;
  assign res_take = res_valid_i && res_ready_i;

  // permit only while coasting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_brakes_i |-> res_phase_i == PhaseCodeCoasting)
    else $error("brake permit outside coasting");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_phase_i) && $stable(res_brakes_i))
    else $error("stalled result changed");

  // fault is terminal: the result right behind it is fault too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take && res_phase_i == PhaseCodeFault |=> !res_valid_i || res_phase_i == PhaseCodeFault)
    else $error("left fault phase");

  // apogee lasts one sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take && res_phase_i == PhaseCodeApogee |=>
      !res_valid_i || res_phase_i == PhaseCodeDescent || res_phase_i == PhaseCodeFault)
    else $error("apogee not followed by descent or fault");

  // descent only gives way to fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take && res_phase_i == PhaseCodeDescent |=>
      !res_valid_i || res_phase_i == PhaseCodeDescent || res_phase_i == PhaseCodeFault)
    else $error("left descent phase");

endmodule

bind flight_phase_sequencer fps_checker u_fps_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_phase_i  (result_o.phase),
  .res_brakes_i (result_o.brakes_allowed)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: flight phase sequencer check
// Drives sample and fault requests through one scripted flight (idle, launch,
// coast, apogee, descent, fault) with bursty input and a stalling result
// consumer. A local flight tracker predicts every phase report; directed rows
// cover field extremes and register corners before the random flight.
// ----------------------------------------------------------------------------
module testbench;
  import fps_pkg::*;

  localparam int WatchdogLimit  = 2000;
  localparam int SettleCycles   = 4;
  localparam int TailCycles     = 10;
  localparam int LongHoldCycles = 48;

  // item indexes where the random flight moves on
  localparam int IdleEnd     = 250;
  localparam int LaunchEnd   = 350;
  localparam int CoastEnd    = 550;
  localparam int FaultAt     = 610;
  localparam int FlightItems = 680;

  typedef enum logic {RowSample, RowWrite} row_kind_e;
  typedef enum logic [1:0] {StallNone, StallCoin, StallComb, StallHeavy} stall_mode_e;

  typedef struct {
    row_kind_e               kind;
    sample_t                 req;
    logic [CfgIdxWidth-1:0]  idx;
    logic [CfgDataWidth-1:0] data;
    bit                      typed;
    result_t                 rep;
  } script_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  fps_sample_if sample_if ();
  fps_result_if result_if ();

  flight_phase_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_if),
    .result_o    (result_if)
  );

  // flight tracker state
  cfg_t                        shadow_cfg;
  logic [PhaseWidth-1:0]       flight_ph;
  logic [CountWidth-1:0]       streak;
  logic [TimeWidth-1:0]        liftoff_time;
  logic signed [DataWidth-1:0] held_tilt;

  result_t     due_reports[$];
  script_row_t script[$];

  int         mismatches    = 0;
  int         reports_seen  = 0;
  int         requests_sent = 0;
  int         writes_done   = 0;
  int         hold_requests = 0;
  int         burst_left    = 0;
  int         quiet         = 0;
  logic [7:0] phases_seen   = '0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic result_t advance_flight(input sample_t s);
    result_t             rep;
    logic [TimeWidth-1:0] elapsed;
    if (s.operation == OpFault) begin
      flight_ph = PhaseCodeFault;
    end else begin
      held_tilt = s.tilt_angle;
      case (flight_ph)
        PhaseCodeIdle: begin
          if ($signed(s.vertical_accel) >= $signed(shadow_cfg.launch_accel_threshold)) begin
            if (streak != CountMax) streak = streak + 1'b1;
            if (streak >= shadow_cfg.confirm_samples) begin
              flight_ph    = PhaseCodeLaunched;
              liftoff_time = s.time_us;
              streak       = '0;
            end
          end else begin
            streak = '0;
          end
        end
        PhaseCodeLaunched: begin
          elapsed = s.time_us - liftoff_time;
          if (elapsed >= shadow_cfg.coast_delay_us) flight_ph = PhaseCodeCoasting;
        end
        PhaseCodeCoasting: begin
          if ($signed(s.vertical_velocity) <= 0) flight_ph = PhaseCodeApogee;
        end
        PhaseCodeApogee: flight_ph = PhaseCodeDescent;
        default: ;
      endcase
    end
    rep.phase          = flight_ph;
    rep.brakes_allowed = (flight_ph == PhaseCodeCoasting) &&
                         ($signed(held_tilt) <= $signed(shadow_cfg.tilt_lock));
    return rep;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.operation         = OpSample;
    s.vertical_accel    = DataWidth'($urandom);
    s.vertical_velocity = DataWidth'($urandom);
    s.tilt_angle        = DataWidth'($urandom);
    s.time_us           = $urandom;
    return s;
  endfunction

  function automatic void add_sample(input logic [DataWidth-1:0] accel,
                                     input logic [DataWidth-1:0] vel,
                                     input logic [DataWidth-1:0] tilt,
                                     input logic [TimeWidth-1:0] t,
                                     input bit typed);
    script_row_t row;
    row.kind                  = RowSample;
    row.req.operation         = OpSample;
    row.req.vertical_accel    = accel;
    row.req.vertical_velocity = vel;
    row.req.tilt_angle        = tilt;
    row.req.time_us           = t;
    row.idx                   = '0;
    row.data                  = '0;
    row.typed                 = typed;
    row.rep.phase             = PhaseCodeIdle;
    row.rep.brakes_allowed    = 1'b0;
    script.push_back(row);
  endfunction

  function automatic void add_write(input logic [CfgIdxWidth-1:0] idx,
                                    input logic [CfgDataWidth-1:0] data);
    script_row_t row;
    row.kind  = RowWrite;
    row.req   = '0;
    row.idx   = idx;
    row.data  = data;
    row.typed = 1'b0;
    row.rep   = '0;
    script.push_back(row);
  endfunction

  task automatic offer_sample(input sample_t req, input bit typed, input result_t typed_rep);
    result_t rep;
    @(negedge clk_i);
    sample_if.valid             <= 1'b1;
    sample_if.operation         <= req.operation;
    sample_if.vertical_accel    <= req.vertical_accel;
    sample_if.vertical_velocity <= req.vertical_velocity;
    sample_if.tilt_angle        <= req.tilt_angle;
    sample_if.time_us           <= req.time_us;
    do @(posedge clk_i); while (!sample_if.ready);
    rep = advance_flight(req);
    if (typed) rep = typed_rep;
    due_reports.push_back(rep);
    requests_sent++;
  endtask

  // bursts of requests with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        sample_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // stop sending and let every outstanding report come back
  task automatic settle();
    @(negedge clk_i);
    sample_if.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgLaunchAccel: shadow_cfg.launch_accel_threshold = data[DataWidth-1:0];
      CfgConfirm:     shadow_cfg.confirm_samples        = data[CountWidth-1:0];
      CfgCoastDelay:  shadow_cfg.coast_delay_us         = data[TimeWidth-1:0];
      CfgTiltLock:    shadow_cfg.tilt_lock              = data[DataWidth-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // result consumer: shifting stall pattern plus long hold-offs on request
  initial begin : result_sink
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    int          served;
    int          tick;
    result_if.ready = 1'b0;
    mode      = StallNone;
    mode_left = 64;
    hold_left = 0;
    served    = 0;
    tick      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && served != hold_requests) begin
        served++;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        tick++;
        case (mode)
          StallNone: result_if.ready <= 1'b1;
          StallCoin: result_if.ready <= 1'($urandom_range(0, 1));
          StallComb: result_if.ready <= (tick % 4) != 3;
          default:   result_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_reports
    result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      reports_seen++;
      phases_seen[result_if.phase] = 1'b1;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected report phase %0d brakes %0d", $time,
                 result_if.phase, result_if.brakes_allowed);
        mismatches++;
      end else begin
        want = due_reports.pop_front();
        if (result_if.phase !== want.phase) begin
          $display("%0t: phase mismatch expected %0d actual %0d", $time,
                   want.phase, result_if.phase);
          mismatches++;
        end
        if (result_if.brakes_allowed !== want.brakes_allowed) begin
          $display("%0t: brakes_allowed mismatch expected %0d actual %0d", $time,
                   want.brakes_allowed, result_if.brakes_allowed);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("%0t: watchdog: no handshake for %0d cycles", $time, quiet);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    sample_t req;
    result_t none;
    int      v;
    bit      qualifies;
    int      next_count;

    rst_ni                      = 1'b0;
    cfg_we_i                    = 1'b0;
    cfg_idx_i                   = CfgLaunchAccel;
    cfg_wdata_i                 = '0;
    sample_if.valid             = 1'b0;
    sample_if.operation         = OpSample;
    sample_if.vertical_accel    = '0;
    sample_if.vertical_velocity = '0;
    sample_if.tilt_angle        = '0;
    sample_if.time_us           = '0;
    none                        = '0;

    shadow_cfg.launch_accel_threshold = RstLaunchAccel;
    shadow_cfg.confirm_samples        = RstConfirm;
    shadow_cfg.coast_delay_us         = RstCoastDelay;
    shadow_cfg.tilt_lock              = RstTiltLock;
    flight_ph    = PhaseCodeIdle;
    streak       = '0;
    liftoff_time = '0;
    held_tilt    = '0;

    // directed rows, all of them stay on the ground
    add_sample(24'd7679, 24'h7FFFFF, 24'h7FFFFF, 32'h0000_0000, 1'b1);
    add_sample(24'd7680, 24'h000000, 24'h000000, 32'h0000_0001, 1'b1);
    add_sample(24'h800000, 24'h800000, 24'h800000, 32'hFFFF_FFFF, 1'b1);
    add_write(CfgLaunchAccel, 32'h007F_FFFF);
    add_sample(24'h7FFFFE, 24'h000001, 24'hFFFFFF, 32'h8000_0000, 1'b1);
    add_sample(24'h7FFFFF, 24'hFFFFFF, 24'h000001, 32'h7FFF_FFFF, 1'b1);
    add_write(CfgConfirm, 32'd255);
    add_write(CfgLaunchAccel, 32'hFF80_0000);
    add_sample(24'h800000, 24'h123456, 24'h654321, 32'h0000_1000, 1'b1);
    add_sample(24'h123456, 24'hABCDEF, 24'h5A5A5A, 32'hA5A5_A5A5, 1'b0);
    // zero confirm count, with nothing able to qualify
    add_write(CfgLaunchAccel, 32'h007F_FFFF);
    add_write(CfgConfirm, 32'd0);
    add_sample(24'h7FFFFE, 24'hA5A5A5, 24'h3C3C3C, 32'h5A5A_5A5A, 1'b1);
    add_write(CfgCoastDelay, 32'h0000_0000);
    add_write(CfgCoastDelay, 32'hFFFF_FFFF);
    add_write(CfgTiltLock, 32'hFF80_0000);
    add_write(CfgTiltLock, 32'h007F_FFFF);
    add_write(CfgLaunchAccel, 32'd7680);
    add_write(CfgConfirm, 32'd5);
    add_write(CfgCoastDelay, 32'd3000000);
    add_write(CfgTiltLock, 32'd7680);
    add_sample(24'd7680, 24'h0F0F0F, 24'h001E00, 32'h0000_0100, 1'b0);
    add_sample(24'd7679, 24'hF0F0F0, 24'h001E01, 32'h0000_0200, 1'b1);

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == RowWrite) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        offer_sample(script[i].req, script[i].typed, script[i].rep);
        pace();
      end
    end

    // one full flight, mostly well-formed with random content
    for (int n = 0; n < FlightItems; n++) begin
      if (n < IdleEnd - 10 && n % 50 == 25) begin
        settle();
        v = $urandom_range(0, 8388608) - 4194304;
        write_reg(CfgLaunchAccel, 32'(v));
        write_reg(CfgConfirm, ($urandom_range(0, 5) == 0) ? 32'd255 : 32'($urandom_range(0, 12)));
      end
      if (n == IdleEnd - 10) begin
        settle();
        write_reg(CfgConfirm, 32'd200);
      end
      if (n == IdleEnd) begin
        // confirm count dropped below a count already in progress
        settle();
        write_reg(CfgConfirm, 32'($urandom_range(0, streak - 1)));
        write_reg(CfgCoastDelay, ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 100000))
                                                             : 32'($urandom_range(1, 32'h8000_0000)));
      end
      if (n == IdleEnd + 50) begin
        settle();
        write_reg(CfgCoastDelay, 32'hFFFF_FFFF);
      end
      if (n == 400 || n == 450 || n == 500) begin
        settle();
        case (n)
          400:     write_reg(CfgTiltLock, 32'hFF80_0000);
          450:     write_reg(CfgTiltLock, 32'h007F_FFFF);
          default: write_reg(CfgTiltLock, 32'($urandom_range(0, 30720)) - 32'd15360);
        endcase
      end
      if (n == 580) begin
        settle();
        write_reg(CfgLaunchAccel, $urandom);
        write_reg(CfgConfirm, $urandom);
        write_reg(CfgCoastDelay, $urandom);
        write_reg(CfgTiltLock, $urandom);
      end
      if (n == 100 || n == 420) hold_requests++;

      req = random_sample();
      case (flight_ph)
        PhaseCodeIdle: begin
          if (n >= IdleEnd - 10) begin
            req.vertical_accel = shadow_cfg.launch_accel_threshold + 24'($urandom_range(0, 255));
            req.time_us        = 32'hFFFF_0000 + 32'($urandom_range(0, 16'hFFFF));
          end else begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: req.vertical_accel = shadow_cfg.launch_accel_threshold +
                                               24'($urandom_range(0, 300));
              4:          req.vertical_accel = shadow_cfg.launch_accel_threshold;
              5:          req.vertical_accel = shadow_cfg.launch_accel_threshold - 24'd1;
              6, 7:       req.vertical_accel = shadow_cfg.launch_accel_threshold -
                                               24'($urandom_range(1, 300));
              default: ;
            endcase
          end
          // hold the launch back until the idle stretch is over
          qualifies  = $signed(req.vertical_accel) >= $signed(shadow_cfg.launch_accel_threshold);
          next_count = (streak == CountMax) ? int'(streak) : int'(streak) + 1;
          if (n < IdleEnd && qualifies && next_count >= int'(shadow_cfg.confirm_samples))
            req.vertical_accel = shadow_cfg.launch_accel_threshold - 24'd1 -
                                 24'($urandom_range(0, 100));
        end
        PhaseCodeLaunched: begin
          if (n < LaunchEnd) begin
            if ($urandom_range(0, 3) == 0)
              req.time_us = liftoff_time + shadow_cfg.coast_delay_us - 32'd1;
            else
              req.time_us = liftoff_time + $urandom_range(0, shadow_cfg.coast_delay_us - 1);
          end else begin
            req.time_us = liftoff_time + shadow_cfg.coast_delay_us;
          end
        end
        PhaseCodeCoasting: begin
          if (n < CoastEnd)
            req.vertical_velocity = 24'($urandom_range(1, 24'h7FFFFF));
          else if ($urandom_range(0, 1) == 0)
            req.vertical_velocity = '0;
          else
            req.vertical_velocity = 24'h800000 | 24'($urandom);
          case ($urandom_range(0, 3))
            0:       req.tilt_angle = shadow_cfg.tilt_lock;
            1:       req.tilt_angle = shadow_cfg.tilt_lock + 24'd1;
            2:       req.tilt_angle = shadow_cfg.tilt_lock - 24'd1;
            default: ;
          endcase
        end
        default: ;
      endcase
      if (n == FaultAt) req.operation = OpFault;
      else if (n > FaultAt) req.operation = 1'($urandom_range(0, 1));

      offer_sample(req, 1'b0, none);
      pace();
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d requests and %0d reports over one flight with %0d register writes",
             requests_sent, reports_seen, writes_done);
    $display("phase codes reported (bit per code): %b, mismatches: %0d", phases_seen, mismatches);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
